FILE: hdl/paged_address_split_translator_defines.svh
// Assertion macros for the paged address split translator.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef PAGED_ADDRESS_SPLIT_TRANSLATOR_DEFINES_SVH
`define PAGED_ADDRESS_SPLIT_TRANSLATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Assertion with an explicit clock and active-low reset.
`define PAT_ASSERT_CR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("paged translator assertion failed");
// Assertion on the block clock and reset.
`define PAT_ASSERT(lbl, prop) `PAT_ASSERT_CR(lbl, clk_i, rst_ni, prop)
`else
`define PAT_ASSERT_CR(lbl, clk, rstn, prop)
`define PAT_ASSERT(lbl, prop)
`endif
`endif

FILE: hdl/pat_pkg.sv
// Shared types and constants of the paged address split translator.
// Used by pat_div and the top level; depends on nothing.
package pat_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PSIZE_W   = 17;
  localparam int unsigned LEN_W     = 12;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned PAGE_W    = 26;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [PSIZE_W-1:0] MIN_PAGE = 17'd64;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_XLATE  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ABSENT  = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  typedef struct packed {
    logic                mode;
    logic [ADDR_W-1:0]   logical_addr;
    logic [LEN_W-1:0]    access_length;
    logic [7:0]          entry_index;
    logic [FRAME_W-1:0]  entry_frame;
    logic                entry_present;
    logic                entry_valid;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_addr;
    logic [LEN_W-1:0]  chunk_length;
    logic [1:0]        status;
    logic              last;
  } out_beat_t;

  typedef struct packed {
    logic               start;
    logic [ADDR_W-1:0]  dividend;
    logic [PSIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ADDR_W-1:0]  quotient;
    logic [PSIZE_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOK,
    ST_MUL
  } state_e;

endpackage

FILE: hdl/pat_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pat_pkg for the request and response structs.
module pat_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pat_pkg::div_req_t req_i,
  output pat_pkg::div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [pat_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [pat_pkg::ADDR_W-1:0]      quo_q, quo_d;
  logic [pat_pkg::PSIZE_W-1:0]     rem_q, rem_d;
  logic [pat_pkg::PSIZE_W-1:0]     dvs_q, dvs_d;
  logic [pat_pkg::PSIZE_W+1:0]     trial;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {1'b0, rem_q, quo_q[pat_pkg::ADDR_W-1]} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial[pat_pkg::PSIZE_W+1]) begin
        rem_d = {rem_q[pat_pkg::PSIZE_W-2:0], quo_q[pat_pkg::ADDR_W-1]};
        quo_d = {quo_q[pat_pkg::ADDR_W-2:0], 1'b0};
      end else begin
        rem_d = trial[pat_pkg::PSIZE_W-1:0];
        quo_d = {quo_q[pat_pkg::ADDR_W-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pat_pkg::DIV_CNT_W'(pat_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: hdl/paged_address_split_translator.sv
// Top level of the paged address split translator: page table, sequencer and output beat.
// Depends on pat_pkg, pat_div and paged_address_split_translator_defines.svh.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   in       | input     | in_valid_i / in_stall_o | pat_pkg::in_beat_t
//   out      | output    | out_valid_o / out_stall_i | pat_pkg::out_beat_t
//   cfg      | input     | cfg_we_i               | cfg_wdata_i (page size)
//
// A translation reaches its first beat through an accept, 32 divider steps, a
// handoff, a table read and a multiply; each further piece then takes a
// registered table read and the frame multiply.
// Reset clears the valid marks, the page size (to 64) and all control state.
// A stalled output holds the sequencer; the next item is taken while the last
// beat of a run still waits in the output register.
`include "paged_address_split_translator_defines.svh"

module paged_address_split_translator #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned MAX_LENGTH  = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pat_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pat_pkg::out_beat_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pat_pkg::PSIZE_W-1:0]   cfg_wdata_i
);

  localparam int unsigned TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [pat_pkg::LEN_W:0] MAX_LEN_C = (pat_pkg::LEN_W + 1)'(MAX_LENGTH);
  localparam logic [pat_pkg::PAGE_W-1:0] DEPTH_PG = pat_pkg::PAGE_W'(TABLE_DEPTH);
  localparam logic [pat_pkg::PSIZE_W-1:0] DEPTH_IX = pat_pkg::PSIZE_W'(TABLE_DEPTH);

  pat_pkg::state_e                 state_q, state_d;
  logic [pat_pkg::PSIZE_W-1:0]     page_size_q;
  logic [pat_pkg::PSIZE_W-1:0]     psize_eff;

  // Run state: bytes still to cover, current page and offset within it.
  logic [pat_pkg::LEN_W-1:0]       rem_len_q, rem_len_d;
  logic [pat_pkg::PAGE_W-1:0]      page_q, page_d;
  logic [pat_pkg::PSIZE_W-1:0]     offset_q, offset_d;

  // Page table: valid marks in flip-flops, frame and present mark in memory.
  logic [TABLE_DEPTH-1:0]          valid_q;
  logic [pat_pkg::FRAME_W:0]       tbl_mem [TABLE_DEPTH];
  logic [pat_pkg::FRAME_W:0]       rd_q;
  logic [TBL_AW-1:0]               wr_addr;
  logic [TBL_AW-1:0]               rd_addr;

  pat_pkg::out_beat_t              out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  pat_pkg::div_req_t               div_req;
  pat_pkg::div_rsp_t               div_rsp;

  logic                            in_stall;
  logic                            in_accept;
  logic                            start_xlate;
  logic                            tbl_we;
  logic                            load_err;
  logic                            load_piece;
  logic                            out_free;
  logic [pat_pkg::LEN_W-1:0]       len_eff;
  logic                            entry_ok;
  logic [pat_pkg::PSIZE_W-1:0]     room;
  logic                            fits;
  logic [pat_pkg::ADDR_W:0]        prod;

  // Page sizes below the minimum behave as the minimum.
  assign psize_eff = (page_size_q < pat_pkg::MIN_PAGE) ? pat_pkg::MIN_PAGE : page_size_q;

  assign in_accept = in_valid_i && !in_stall;
  assign len_eff   = ({1'b0, in_data_i.access_length} > MAX_LEN_C) ?
                     pat_pkg::LEN_W'(MAX_LENGTH) : in_data_i.access_length;

  // A translation with zero length gives no beat and never leaves idle.
  assign start_xlate = in_accept && (in_data_i.mode == pat_pkg::MODE_XLATE) &&
                       (len_eff != '0);
  assign tbl_we      = in_accept && (in_data_i.mode == pat_pkg::MODE_WRITE) &&
                       (pat_pkg::PSIZE_W'(in_data_i.entry_index) < DEPTH_IX);
  assign wr_addr     = TBL_AW'(in_data_i.entry_index);
  assign rd_addr     = page_q[TBL_AW-1:0];

  // The output register can take a beat when it is empty or is being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // A page past the table end counts as missing, like an invalid entry.
  assign entry_ok = (page_q < DEPTH_PG) && valid_q[rd_addr];

  assign room = psize_eff - offset_q;
  assign fits = room >= pat_pkg::PSIZE_W'(rem_len_q);
  assign prod = (pat_pkg::ADDR_W + 1)'(rd_q[pat_pkg::FRAME_W-1:0]) *
                (pat_pkg::ADDR_W + 1)'(psize_eff);

  assign div_req.start    = start_xlate;
  assign div_req.dividend = in_data_i.logical_addr;
  assign div_req.divisor  = psize_eff;

  pat_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pat_pkg::ST_IDLE: begin
        if (start_xlate) begin
          state_d = pat_pkg::ST_DIV;
        end
      end
      pat_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = pat_pkg::ST_LOOK;
        end
      end
      pat_pkg::ST_LOOK: begin
        if (!entry_ok) begin
          if (out_free) begin
            state_d = pat_pkg::ST_IDLE;
          end
        end else begin
          state_d = pat_pkg::ST_MUL;
        end
      end
      pat_pkg::ST_MUL: begin
        if (out_free) begin
          state_d = fits ? pat_pkg::ST_IDLE : pat_pkg::ST_LOOK;
        end
      end
      default: state_d = pat_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall   = 1'b1;
    load_err   = 1'b0;
    load_piece = 1'b0;
    case (state_q)
      pat_pkg::ST_IDLE: in_stall = 1'b0;
      pat_pkg::ST_DIV:  in_stall = 1'b1;
      pat_pkg::ST_LOOK: load_err = !entry_ok && out_free;
      pat_pkg::ST_MUL:  load_piece = out_free;
      default:          in_stall = 1'b1;
    endcase
  end

  // Run registers and the output beat.
  always_comb begin
    rem_len_d   = rem_len_q;
    page_d      = page_q;
    offset_d    = offset_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (start_xlate) begin
      rem_len_d = len_eff;
    end
    if ((state_q == pat_pkg::ST_DIV) && div_rsp.done) begin
      page_d   = div_rsp.quotient[pat_pkg::PAGE_W-1:0];
      offset_d = div_rsp.remainder;
    end

    if (load_err) begin
      out_valid_d        = 1'b1;
      out_d.phys_addr    = '0;
      out_d.chunk_length = '0;
      out_d.status       = pat_pkg::STATUS_MISSING;
      out_d.last         = 1'b1;
    end

    if (load_piece) begin
      out_valid_d        = 1'b1;
      out_d.phys_addr    = prod[pat_pkg::ADDR_W-1:0] + pat_pkg::ADDR_W'(offset_q);
      out_d.chunk_length = fits ? rem_len_q : room[pat_pkg::LEN_W-1:0];
      out_d.status       = rd_q[pat_pkg::FRAME_W] ? pat_pkg::STATUS_OK :
                                                    pat_pkg::STATUS_ABSENT;
      out_d.last         = fits;
      if (!fits) begin
        // The piece ran to the page end: carry on at the start of the next page.
        rem_len_d = rem_len_q - room[pat_pkg::LEN_W-1:0];
        offset_d  = '0;
        page_d    = page_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pat_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      page_size_q <= pat_pkg::MIN_PAGE;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        page_size_q <= cfg_wdata_i;
      end
      if (tbl_we) begin
        valid_q[wr_addr] <= in_data_i.entry_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_len_q <= rem_len_d;
    page_q    <= page_d;
    offset_q  <= offset_d;
    out_q     <= out_d;
  end

  // Frame memory with a registered read; the address only moves between pieces.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[wr_addr] <= {in_data_i.entry_present, in_data_i.entry_frame};
    end
    rd_q <= tbl_mem[rd_addr];
  end

  assign in_stall_o  = in_stall;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The quotient only arrives while the sequencer waits for it.
  `PAT_ASSERT(a_div_done_in_div, div_rsp.done |-> state_q == pat_pkg::ST_DIV)
  // An error beat is always the closing beat of its run and covers no bytes.
  `PAT_ASSERT(a_err_beat_shape, out_valid_o && out_data_o.status == pat_pkg::STATUS_MISSING |-> out_data_o.last && out_data_o.chunk_length == '0)
  // A piece never overwrites a beat that is still waiting to be taken.
  `PAT_ASSERT(a_no_overwrite, load_piece || load_err |-> !out_valid_q || !out_stall_i)

endmodule

FILE: bench/tb_paged_address_split_translator.sv
// Self-checking testbench for paged_address_split_translator: table writes, page-split translation.
// Depends on pat_pkg and the RTL; output beats are checked against a predictor kept in the bench.
module tb_paged_address_split_translator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned LEN_LIMIT  = 2048;
  // Cycles allowed after the last beat for a table write still in flight.
  localparam int unsigned SETTLE     = 40;
  // Random translations mostly stay in this low window of pages, which the
  // fill test makes valid, so long runs across many pages are common.
  localparam int unsigned FILL_PAGES = 64;
  localparam int unsigned END_LIMIT  = 200000;
  localparam int unsigned PRINT_CAP  = 40;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  pat_pkg::in_beat_t           in_data   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  pat_pkg::out_beat_t          out_data;
  logic                        cfg_we    = 1'b0;
  logic [pat_pkg::PSIZE_W-1:0] cfg_wdata = '0;

  // Bench copy of the page table and the page size register.
  logic [pat_pkg::FRAME_W-1:0] frame_copy   [DEPTH];
  logic                        present_copy [DEPTH];
  logic                        valid_copy   [DEPTH];
  logic [pat_pkg::PSIZE_W-1:0] page_size_copy = pat_pkg::MIN_PAGE;

  // Translated pieces still owed by the block, oldest first.
  pat_pkg::out_beat_t pending_pieces [$];

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 76;
  int unsigned beats_sent    = 0;
  int unsigned writes_sent   = 0;
  int unsigned beats_checked = 0;
  int unsigned absent_seen   = 0;
  int unsigned missing_seen  = 0;
  int unsigned sizes_used    = 0;
  int unsigned mismatches    = 0;

  paged_address_split_translator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    mismatches++;
  endtask

  // Applies one accepted input beat to the bench copy of the block. A write
  // updates all three marks of its entry; a translation walks page by page and
  // queues one piece per page touched. A page that is not valid, or that lies
  // past the end of the table, closes the run with a single error piece.
  function automatic void predict_beat(input pat_pkg::in_beat_t beat);
    longint unsigned psize, page, offset, remaining, room, phys;
    pat_pkg::out_beat_t piece;
    if (beat.mode == pat_pkg::MODE_WRITE) begin
      // The index is eight bits wide, so every write lands inside the table.
      frame_copy[beat.entry_index]   = beat.entry_frame;
      present_copy[beat.entry_index] = beat.entry_present;
      valid_copy[beat.entry_index]   = beat.entry_valid;
      return;
    end
    // Page sizes under the minimum, zero included, behave as the minimum.
    psize     = (page_size_copy < pat_pkg::MIN_PAGE) ? pat_pkg::MIN_PAGE : page_size_copy;
    // Over-long accesses are cut down to the maximum length.
    remaining = (beat.access_length > LEN_LIMIT) ? LEN_LIMIT : beat.access_length;
    page      = beat.logical_addr / psize;
    offset    = beat.logical_addr % psize;
    while (remaining != 0) begin
      if (page >= DEPTH || !valid_copy[page]) begin
        piece.phys_addr    = '0;
        piece.chunk_length = '0;
        piece.status       = pat_pkg::STATUS_MISSING;
        piece.last         = 1'b1;
        pending_pieces.push_back(piece);
        return;
      end
      room = psize - offset;
      // The physical address wraps at 32 bits.
      phys = frame_copy[page] * psize + offset;
      piece.phys_addr = phys[pat_pkg::ADDR_W-1:0];
      piece.status    = present_copy[page] ? pat_pkg::STATUS_OK : pat_pkg::STATUS_ABSENT;
      if (room >= remaining) begin
        piece.chunk_length = remaining[pat_pkg::LEN_W-1:0];
        piece.last         = 1'b1;
        pending_pieces.push_back(piece);
        return;
      end
      piece.chunk_length = room[pat_pkg::LEN_W-1:0];
      piece.last         = 1'b0;
      pending_pieces.push_back(piece);
      remaining -= room;
      offset     = 0;
      page++;
    end
  endfunction

  // Write-mode beat; the translation fields carry random values that the
  // block must ignore.
  function automatic pat_pkg::in_beat_t entry_write_beat(
      input logic [7:0]                  idx,
      input logic [pat_pkg::FRAME_W-1:0] frame,
      input logic                        present,
      input logic                        valid);
    pat_pkg::in_beat_t beat;
    beat.mode          = pat_pkg::MODE_WRITE;
    beat.logical_addr  = $urandom();
    beat.access_length = pat_pkg::LEN_W'($urandom());
    beat.entry_index   = idx;
    beat.entry_frame   = frame;
    beat.entry_present = present;
    beat.entry_valid   = valid;
    return beat;
  endfunction

  // Translate-mode beat; the entry fields carry random values.
  function automatic pat_pkg::in_beat_t access_beat(
      input logic [pat_pkg::ADDR_W-1:0] addr,
      input logic [pat_pkg::LEN_W-1:0]  len);
    pat_pkg::in_beat_t beat;
    beat.mode          = pat_pkg::MODE_XLATE;
    beat.logical_addr  = addr;
    beat.access_length = len;
    beat.entry_index   = 8'($urandom());
    beat.entry_frame   = pat_pkg::FRAME_W'($urandom());
    beat.entry_present = 1'($urandom());
    beat.entry_valid   = 1'($urandom());
    return beat;
  endfunction

  // Sends one beat. Random idle cycles come first; valid then stays high
  // until the beat is taken. Valid is left high on return, so a following
  // call in the same time step simply replaces the payload.
  task automatic send_beat(input pat_pkg::in_beat_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(beat);
    beats_sent++;
    if (beat.mode == pat_pkg::MODE_WRITE) begin
      writes_sent++;
    end
  endtask

  // Holds the input side off until every owed piece has come back.
  task automatic wait_for_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pieces.size() != 0) @(posedge clk);
  endtask

  // The page size is only changed with the block idle: no piece owed and
  // time enough for a trailing table write to finish.
  task automatic set_page_size(input logic [pat_pkg::PSIZE_W-1:0] bytes);
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we    <= 1'b0;
    page_size_copy = bytes;
    sizes_used++;
  endtask

  // Right after reset no entry is valid, so every translation fails on its
  // first page, including the longest clamped access at the top address.
  task automatic test_empty_table;
    send_beat(access_beat(32'd0, 12'd1));
    send_beat(access_beat(32'hFFFF_FFFF, 12'hFFF));
  endtask

  // Runs at the reset page size of 64 bytes through the main cases: single
  // piece, page crossing into a page that is not present, a missing page in
  // mid-run, an access ending exactly at a page end, running off the end of
  // the table, a zero length, a clamped length and removal of an entry.
  task automatic test_directed_runs;
    send_beat(entry_write_beat(8'd0, 16'h0000, 1'b1, 1'b1));
    send_beat(entry_write_beat(8'd1, 16'hFFFF, 1'b0, 1'b1));
    send_beat(entry_write_beat(8'd2, 16'h0003, 1'b1, 1'b1));
    send_beat(entry_write_beat(8'd255, 16'h8000, 1'b1, 1'b1));
    send_beat(entry_write_beat(8'd3, 16'h0007, 1'b1, 1'b0));
    send_beat(access_beat(32'd0, 12'd1));
    send_beat(access_beat(32'd63, 12'd2));
    send_beat(access_beat(32'd74, 12'(LEN_LIMIT)));
    send_beat(access_beat(32'd255 * 64 + 5, 12'd59));
    send_beat(access_beat(32'd255 * 64, 12'd65));
    send_beat(access_beat(32'd100, 12'd0));
    send_beat(access_beat(32'd0, 12'hFFF));
    send_beat(entry_write_beat(8'd2, 16'h0003, 1'b1, 1'b0));
    send_beat(access_beat(32'd128, 12'd1));
  endtask

  // Page size register at its edges: zero and 63 act as the minimum, 65 is
  // just above it, the largest 17-bit value makes the physical address wrap,
  // and 65536 with the top frame reaches the highest physical byte.
  task automatic test_page_size_extremes;
    set_page_size(17'd0);
    send_beat(access_beat(32'd70, 12'd1));
    set_page_size(17'd63);
    send_beat(access_beat(32'd0, 12'd65));
    set_page_size(17'd65);
    send_beat(access_beat(32'd64, 12'd2));
    set_page_size(17'h1FFFF);
    send_beat(access_beat(32'd131070, 12'd3));
    set_page_size(17'd65536);
    send_beat(access_beat(32'd65536 + 32'd65535, 12'd1));
  endtask

  // Makes the low pages valid with random frames, then sends the two longest
  // runs at the minimum page size: 32 whole pages, and 33 pieces when the
  // start sits mid-page.
  task automatic test_fill_table;
    set_page_size(pat_pkg::MIN_PAGE);
    for (int unsigned p = 0; p < FILL_PAGES; p++) begin
      send_beat(entry_write_beat(8'(p), pat_pkg::FRAME_W'($urandom()), 1'($urandom()), 1'b1));
    end
    send_beat(access_beat(32'd0, 12'(LEN_LIMIT)));
    send_beat(access_beat(32'd32, 12'(LEN_LIMIT)));
  endtask

  // Random traffic at one page size. Most beats are translations into the
  // filled window with starts often near a page end; about a fifth rewrite
  // entries, and the rest are fully random beats of either mode. Halfway
  // through, and now and then at random, the sender waits for all results.
  task automatic test_random_traffic(input logic [pat_pkg::PSIZE_W-1:0] bytes,
                                     input int unsigned count,
                                     input int unsigned send_pct,
                                     input int unsigned recv_pct);
    pat_pkg::in_beat_t         beat;
    longint unsigned           psize, page, offset;
    logic [pat_pkg::LEN_W-1:0] len;
    int unsigned               pick;
    set_page_size(bytes);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    psize = (bytes < pat_pkg::MIN_PAGE) ? pat_pkg::MIN_PAGE : bytes;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        beat = entry_write_beat(($urandom_range(3) != 0) ? 8'($urandom_range(FILL_PAGES - 1))
                                                         : 8'($urandom()),
                                pat_pkg::FRAME_W'($urandom()), 1'($urandom()),
                                $urandom_range(9) != 0);
      end else if (pick < 88) begin
        page   = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 7)
                                          : $urandom_range(FILL_PAGES - 1);
        offset = ($urandom_range(1) != 0) ? $urandom() % psize
                                          : psize - 1 - $urandom_range(63);
        case ($urandom_range(19))
          0:       len = '0;
          1:       len = pat_pkg::LEN_W'($urandom_range(LEN_LIMIT + 1, 4095));
          2, 3:    len = pat_pkg::LEN_W'(LEN_LIMIT);
          4, 5, 6, 7, 8, 9: begin
            len = pat_pkg::LEN_W'($urandom_range(1, LEN_LIMIT));
          end
          default: len = pat_pkg::LEN_W'($urandom_range(1, 200));
        endcase
        beat = access_beat(pat_pkg::ADDR_W'(page * psize + offset), len);
      end else begin
        beat.mode          = 1'($urandom());
        beat.logical_addr  = $urandom();
        beat.access_length = pat_pkg::LEN_W'($urandom());
        beat.entry_index   = 8'($urandom());
        beat.entry_frame   = pat_pkg::FRAME_W'($urandom());
        beat.entry_present = 1'($urandom());
        beat.entry_valid   = 1'($urandom());
      end
      send_beat(beat);
      if (k == count / 2 || $urandom_range(29) == 0) begin
        wait_for_results();
      end
    end
  endtask

  // Output side: a beat is taken at an edge with valid high and stall low,
  // both as they stood before the edge. The stall for the next cycle is
  // drawn here as well.
  always @(posedge clk) begin : check_output
    pat_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pieces.size() == 0) begin
        report_mismatch($sformatf("unexpected beat addr %h len %0d status %0d last %0b",
                                  out_data.phys_addr, out_data.chunk_length,
                                  out_data.status, out_data.last));
      end else begin
        want = pending_pieces.pop_front();
        if (out_data.phys_addr !== want.phys_addr) begin
          report_mismatch($sformatf("phys_addr %h, expected %h",
                                    out_data.phys_addr, want.phys_addr));
        end
        if (out_data.chunk_length !== want.chunk_length) begin
          report_mismatch($sformatf("chunk_length %0d, expected %0d",
                                    out_data.chunk_length, want.chunk_length));
        end
        if (out_data.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data.status, want.status));
        end
        if (out_data.last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", out_data.last, want.last));
        end
        beats_checked++;
        if (want.status == pat_pkg::STATUS_ABSENT) begin
          absent_seen++;
        end
        if (want.status == pat_pkg::STATUS_MISSING) begin
          missing_seen++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    int unsigned waited;
    foreach (valid_copy[i]) begin
      valid_copy[i]   = 1'b0;
      present_copy[i] = 1'b0;
      frame_copy[i]   = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_directed_runs();
    test_page_size_extremes();
    test_fill_table();
    // Sender idles lightly while the receiver stalls hard, then the reverse,
    // then full throughput on both sides.
    test_random_traffic(pat_pkg::MIN_PAGE, 45, 35, 76);
    test_random_traffic(17'd65536, 45, 35, 76);
    test_random_traffic(17'd100, 45, 76, 35);
    test_random_traffic(17'h1FFFF, 45, 76, 35);
    test_random_traffic(17'd4097, 45, 0, 0);

    // Drain: wait for owed pieces within a bound, then watch a little longer
    // for any beat the block should not send.
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_pieces.size() != 0 && waited < END_LIMIT);
    repeat (SETTLE) @(posedge clk);
    if (pending_pieces.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", pending_pieces.size()));
    end

    $display("Sent %0d input beats (%0d table writes) across %0d page size settings.",
             beats_sent, writes_sent, sizes_used);
    $display("Checked %0d output beats, %0d with page not present and %0d with page missing.",
             beats_checked, absent_seen, missing_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #30_000_000;
    $display("Timeout: the run did not complete in time.");
    $display("Verification failed");
    $finish;
  end

endmodule
